// ===== sv/direction_to_equirect_texel_macros.svh =====
// ----------------------------------------------------------------------------
// Equirectangular texel lookup assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DIRECTION_TO_EQUIRECT_TEXEL_MACROS_SVH
`define DIRECTION_TO_EQUIRECT_TEXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dte_pkg.sv =====
// ----------------------------------------------------------------------------
// Equirectangular texel lookup package
// Widths, stage plan, arctangent table and the per-stage arithmetic.
// ----------------------------------------------------------------------------
package dte_pkg;

   localparam int unsigned DIR_BITS      = 16;
   localparam int unsigned DIR_FRAC_BITS = 15;
   localparam int unsigned COORD_BITS    = 12;
   localparam int unsigned ANGLE_BITS    = 16;
   localparam int unsigned CFG_BITS      = 13;
   localparam int unsigned XY_BITS       = 36;
   localparam int unsigned ROOT_BITS     = 62;

   // Register indexes on the configuration port.
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd512;

   // Stage plan: entry, azimuth and square-root steps, polar CORDIC, scaling.
   localparam int unsigned AZ_FIRST   = 1;
   localparam int unsigned AZ_LAST    = 32;
   localparam int unsigned SQ_LAST    = 31;
   localparam int unsigned PO_INIT    = 32;
   localparam int unsigned PO_FIRST   = 33;
   localparam int unsigned PO_LAST    = 64;
   localparam int unsigned MUL_STAGE  = 65;
   localparam int unsigned NUM_STAGES = 66;
   localparam int unsigned LATENCY    = NUM_STAGES + 1;

   localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
   localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

   // atan(2^-i) in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic [31:0]               ang;
      logic                      done;
   } rot_type;

   typedef struct packed {
      logic [ROOT_BITS-1:0] n;
      logic [ROOT_BITS-1:0] r;
   } sq_type;

   typedef struct packed {
      rot_type            az;
      rot_type            po;
      sq_type             sq;
      logic signed [31:0] pz;
      logic [12:0]        col_p;
      logic [13:0]        row_p;
   } pipe_type;

   // Vectoring CORDIC set-up: axis cases get exact angles, left half is folded.
   function automatic rot_type cordic_init(input logic signed [XY_BITS-1:0] x,
                                           input logic signed [XY_BITS-1:0] y);
      rot_type o;
      o.x    = x;
      o.y    = y;
      o.ang  = '0;
      o.done = 1'b0;
      if (y == '0) begin
         o.ang  = (x < 0) ? TURN_HALF : '0;
         o.done = 1'b1;
      end else if (x == '0) begin
         o.ang  = (y > 0) ? TURN_QUARTER : TURN_HALF + TURN_QUARTER;
         o.done = 1'b1;
      end else if (x < 0) begin
         o.x   = -x;
         o.y   = -y;
         o.ang = TURN_HALF;
      end
      return o;
   endfunction

   // One CORDIC rotation; shifts floor toward minus infinity.
   function automatic rot_type cordic_step(input rot_type s, input logic [4:0] i);
      rot_type                   o;
      logic signed [XY_BITS-1:0] sx;
      logic signed [XY_BITS-1:0] sy;
      o  = s;
      sx = s.x >>> i;
      sy = s.y >>> i;
      if (!s.done) begin
         if (s.y > 0) begin
            o.x   = s.x + sy;
            o.y   = s.y - sx;
            o.ang = s.ang + ATAN_TURNS[i];
         end else begin
            o.x   = s.x - sy;
            o.y   = s.y + sx;
            o.ang = s.ang - ATAN_TURNS[i];
         end
      end
      return o;
   endfunction

   // One digit of the restoring integer square root, trial bit 4^j.
   function automatic sq_type sqrt_step(input sq_type s, input logic [4:0] j);
      sq_type               o;
      logic [ROOT_BITS-1:0] bit_v;
      logic [ROOT_BITS-1:0] trial;
      bit_v = ROOT_BITS'(1) << {j, 1'b0};
      trial = s.r + bit_v;
      if (s.n >= trial) begin
         o.n = s.n - trial;
         o.r = (s.r >> 1) + bit_v;
      end else begin
         o.n = s.n;
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // Entry stage: azimuth set-up, z rescale and the radicand 2^60 - z^2.
   function automatic pipe_type pipe_entry(input logic signed [DIR_BITS-1:0] x,
                                           input logic signed [DIR_BITS-1:0] y,
                                           input logic signed [DIR_BITS-1:0] z);
      pipe_type    o;
      logic [16:0] zabs;
      logic [33:0] zsq;
      o    = '0;
      zabs = z[DIR_BITS-1] ? 17'd0 - {z[DIR_BITS-1], z} : {1'b0, z};
      zsq  = 34'(zabs * zabs);
      o.az = cordic_init({{4{x[DIR_BITS-1]}}, x, 16'h0000},
                         {{4{y[DIR_BITS-1]}}, y, 16'h0000});
      o.pz = {z[DIR_BITS-1], z, 15'h0000};
      o.sq.n = (ROOT_BITS'(1) << 60) - ROOT_BITS'({zsq, 30'd0});
      o.sq.r = '0;
      return o;
   endfunction

   // Work of pipeline stage k.
   function automatic pipe_type pipe_step(input pipe_type s, input logic [6:0] k,
                                          input logic [CFG_BITS-1:0] w,
                                          input logic [CFG_BITS-1:0] h);
      pipe_type    o;
      logic [28:0] cp;
      logic [28:0] rp;
      o  = s;
      cp = 29'(s.az.ang[31:32-ANGLE_BITS]) * 29'(w);
      rp = 29'(s.po.ang[31:32-ANGLE_BITS]) * 29'(h);
      if (k >= AZ_FIRST && k <= AZ_LAST)
         o.az = cordic_step(s.az, 5'(k - 7'd1));
      if (k >= 1 && k <= SQ_LAST)
         o.sq = sqrt_step(s.sq, 5'(7'd31 - k));
      if (k == PO_INIT)
         o.po = cordic_init({{4{s.pz[31]}}, s.pz}, {4'b0000, s.sq.r[31:0]});
      if (k >= PO_FIRST && k <= PO_LAST)
         o.po = cordic_step(s.po, 5'(k - 7'd33));
      if (k == MUL_STAGE) begin
         o.col_p = cp[28:16];
         o.row_p = rp[28:15];
      end
      return o;
   endfunction

   // Clamp a coordinate to the last texel and to the coordinate range.
   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [13:0] c,
                                                       input logic [CFG_BITS-1:0] size);
      logic [13:0] v;
      v = c;
      if (size == '0)
         v = '0;
      else if (c >= {1'b0, size})
         v = {1'b0, size} - 14'd1;
      if (v > 14'd4095)
         v = 14'd4095;
      return v[COORD_BITS-1:0];
   endfunction

endpackage

// ===== sv/direction_to_equirect_texel.sv =====
// ----------------------------------------------------------------------------
// Direction to equirectangular texel
// Maps a unit direction to column and row of an equirectangular map.
// ----------------------------------------------------------------------------
// One item enters per clock cycle while reset is low. Its texel is on the
// rsp_ ports, marked by rsp_valid for one cycle, once the item has passed
// the stage registers and the output register.
// The depth is one entry stage, the 31-step square root of 1 - z^2, one
// stage that sets up the polar CORDIC, its 32 steps, one multiply stage and
// one saturation stage; the azimuth CORDIC runs beside them. The receiver
// cannot stall, so busy is high only during reset. The user must write
// map size registers only while no item is in flight; no check enforces it.
module direction_to_equirect_texel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [dte_pkg::DIR_BITS-1:0] req_dir_x,
   input  logic signed [dte_pkg::DIR_BITS-1:0] req_dir_y,
   input  logic signed [dte_pkg::DIR_BITS-1:0] req_dir_z,
   output logic                                rsp_valid,
   output logic [dte_pkg::COORD_BITS-1:0]      rsp_texel_col,
   output logic [dte_pkg::COORD_BITS-1:0]      rsp_texel_row,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [dte_pkg::CFG_BITS-1:0]        csr_data
);
   import dte_pkg::*;

`include "direction_to_equirect_texel_macros.svh"

   logic [CFG_BITS-1:0]   width_ff;
   logic [CFG_BITS-1:0]   height_ff;
   logic                  accept;
   logic [NUM_STAGES-1:0] valid_ff;
   pipe_type              pipe_ff [NUM_STAGES];
   pipe_type              pipe_in [NUM_STAGES];
   logic                  rsp_valid_ff;
   logic [COORD_BITS-1:0] col_ff;
   logic [COORD_BITS-1:0] row_ff;
   logic                  col_in_map;
   logic                  row_in_map;

   // An item is taken whenever start is high outside reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Map size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  width_ff  <= csr_data;
            REG_MAP_HEIGHT: height_ff <= csr_data;
         endcase
      end
   end

   // Stage logic: entry, then one step of each unit per stage.
   always_comb pipe_in[0] = pipe_entry(req_dir_x, req_dir_y, req_dir_z);

   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
      always_comb pipe_in[k] = pipe_step(pipe_ff[k-1], 7'(k), width_ff, height_ff);
   end

   // Valid bits travel alongside the payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[NUM_STAGES-2:0], accept};
         rsp_valid_ff <= valid_ff[NUM_STAGES-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
      col_ff  <= sat_coord({1'b0, pipe_ff[NUM_STAGES-1].col_p}, width_ff);
      row_ff  <= sat_coord(pipe_ff[NUM_STAGES-1].row_p, height_ff);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_texel_col = col_ff;
   assign rsp_texel_row = row_ff;

   // A coordinate lies inside the map, or is zero for an empty map.
   assign col_in_map = (width_ff == '0) ? (rsp_texel_col == '0)
                                        : ({1'b0, rsp_texel_col} < width_ff);
   assign row_in_map = (height_ff == '0) ? (rsp_texel_row == '0)
                                         : ({1'b0, rsp_texel_row} < height_ff);

   // Checks.
   `DTE_ASSERT_SAME(a_rsp_has_item, rsp_valid, $past(accept, LATENCY), "result without item")
   `DTE_ASSERT_SAME(a_col_in_map, rsp_valid, col_in_map, "column outside map")
   `DTE_ASSERT_SAME(a_row_in_map, rsp_valid, row_in_map, "row outside map")
   `DTE_ASSERT_NEXT(a_last_stage_out, valid_ff[NUM_STAGES-1], rsp_valid, "lost result")

endmodule
